// ===== sv/pnm_pkg.sv =====
// Shared types, codes and constants of the PNM raster expander.
package pnm_pkg;

    // Format mode digits
    localparam logic [2:0] MODE_P1 = 3'd1;
    localparam logic [2:0] MODE_P2 = 3'd2;
    localparam logic [2:0] MODE_P3 = 3'd3;
    localparam logic [2:0] MODE_P4 = 3'd4;
    localparam logic [2:0] MODE_P5 = 3'd5;
    localparam logic [2:0] MODE_P6 = 3'd6;

    // Configuration register indexes
    localparam logic REG_FORMAT_MODE = 1'b0;
    localparam logic REG_ROW_WIDTH   = 1'b1;

    localparam logic [2:0]  FORMAT_MODE_RESET = MODE_P6;
    localparam logic [15:0] ROW_WIDTH_RESET   = 16'd1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] LEVEL_WHITE  = 8'd255;
    localparam logic [7:0] LEVEL_BLACK  = 8'd0;

    // Command kinds passed from the front end to the pixel engine
    localparam logic CMD_PIXEL = 1'b0;  // one finished pixel
    localparam logic CMD_MONO8 = 1'b1;  // a P4 byte, up to eight pixels

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic       kind;
        logic [7:0] red;    // holds the packed bitmap byte for CMD_MONO8
        logic [7:0] green;
        logic [7:0] blue;
    } pnm_cmd_t;

    // Zero is white, one is black
    function automatic logic [7:0] mono_level(input logic bit_value);
        mono_level = bit_value ? LEVEL_BLACK : LEVEL_WHITE;
    endfunction

endpackage

// ===== sv/pnm_in_if.sv =====
// Raster byte channel: valid/ready handshake with byte and end marker.
interface pnm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

// ===== sv/pnm_out_if.sv =====
// Pixel channel: valid/ready handshake with RGBA and framing flags.
interface pnm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       run_last;

    modport source (output valid, output red, output green, output blue,
                    output alpha, output row_end, output run_last, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input alpha, input row_end, input run_last, output ready);
endinterface

// ===== sv/pnm_raster_to_rgba_expander.sv =====
// Top level of the PNM raster to RGBA pixel expander.
//
// Feed the raster bytes of a PNM image (header already stripped) on the raster
// channel, one byte per beat, and take RGBA pixels from the pixel channel;
// alpha is always 255. format_mode (register 0) selects the variant digit:
// 6 packs three bytes per pixel, 5 copies one grey byte to R, G and B, 4 expands
// each byte MSB first into up to eight pixels (1 black, 0 white, bits past the
// end of a row are dropped), and 1/2/3 parse decimal numbers separated by any
// non-digit byte (bitmap, grey, RGB components). row_width (register 1) sets
// the pixels per row, 0 meaning 65536; row_end marks the last pixel of a row
// and run_last the last pixel caused by one input beat. A beat with
// end_of_data set completes a pending ASCII number and is otherwise a no-op.
// Write the registers only while the block is idle.
// Rate: the front end takes one byte per cycle whenever its four-entry command
// queue has room; the pixel engine emits one pixel per cycle while the pixel
// channel is not stalled. A P4 byte holds the engine until every pixel it
// yields (up to eight) has gone out. The output register lets a new pixel load in
// the same cycle the previous one is taken.
module pnm_raster_to_rgba_expander (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    pnm_in_if.sink      raster,
    pnm_out_if.source   pixel
);

    logic [2:0]  format_mode_reg;
    logic [15:0] row_width_reg;

    logic               push;
    pnm_pkg::pnm_cmd_t  push_cmd;
    logic               pop;
    pnm_pkg::pnm_cmd_t  head_cmd;
    logic               head_valid;
    logic               fifo_full;

    // Configuration registers: write-only, taken on any cycle with cfg_we high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_mode_reg <= pnm_pkg::FORMAT_MODE_RESET;
            row_width_reg   <= pnm_pkg::ROW_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pnm_pkg::REG_FORMAT_MODE: format_mode_reg <= cfg_wdata[2:0];
                pnm_pkg::REG_ROW_WIDTH:   row_width_reg   <= cfg_wdata;
                default:                  format_mode_reg <= format_mode_reg;
            endcase
        end
    end

    // Front end: classify each beat, parse numbers, assemble RGB triples
    pnm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .format_mode (format_mode_reg),
        .raster      (raster),
        .fifo_full   (fifo_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // Decouple the two halves so each can stall on its own
    pnm_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .full       (fifo_full)
    );

    // Pixel engine: one pixel per cycle unless the output stalls, row tracking, bitmap expansion
    pnm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .row_width  (row_width_reg),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .pop        (pop),
        .pixel      (pixel)
    );

endmodule

// ===== sv/pnm_front.sv =====
// Front end: accepts raster bytes, parses ASCII numbers, assembles components.
module pnm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         format_mode,
    pnm_in_if.sink             raster,
    input  logic               fifo_full,
    output logic               push,
    output pnm_pkg::pnm_cmd_t  push_cmd
);

    logic [1:0] component_index_reg, component_index_next;
    logic [7:0] held_red_reg, held_red_next;
    logic [7:0] held_green_reg, held_green_next;
    logic [7:0] number_accumulator_reg, number_accumulator_next;
    logic       digits_pending_reg, digits_pending_next;

    logic       accept;
    logic       is_digit;
    logic [7:0] acc_times_ten;

    assign raster.ready  = !fifo_full;
    assign accept        = raster.valid && raster.ready;
    assign is_digit      = (raster.data_byte >= 8'h30) && (raster.data_byte <= 8'h39);
    assign acc_times_ten = {number_accumulator_reg[4:0], 3'b000}
                         + {number_accumulator_reg[6:0], 1'b0};

    always_comb
    begin
        logic       rgb_take;
        logic [7:0] rgb_value;

        component_index_next    = component_index_reg;
        held_red_next           = held_red_reg;
        held_green_next         = held_green_reg;
        number_accumulator_next = number_accumulator_reg;
        digits_pending_next     = digits_pending_reg;
        push                    = 1'b0;
        push_cmd                = '{kind: pnm_pkg::CMD_PIXEL, red: raster.data_byte,
                                    green: raster.data_byte, blue: raster.data_byte};
        rgb_take                = 1'b0;
        rgb_value               = raster.data_byte;

        if (accept)
        begin
            case (format_mode)
                pnm_pkg::MODE_P1, pnm_pkg::MODE_P2, pnm_pkg::MODE_P3:
                begin
                    if (!raster.end_of_data && is_digit)
                    begin
                        number_accumulator_next = acc_times_ten
                                                + {4'b0000, raster.data_byte[3:0]};
                        digits_pending_next     = 1'b1;
                    end
                    else if (digits_pending_reg)
                    begin
                        // complete the pending number
                        number_accumulator_next = 8'd0;
                        digits_pending_next     = 1'b0;
                        if (format_mode == pnm_pkg::MODE_P1)
                        begin
                            push           = 1'b1;
                            push_cmd.red   = pnm_pkg::mono_level(number_accumulator_reg != 8'd0);
                            push_cmd.green = push_cmd.red;
                            push_cmd.blue  = push_cmd.red;
                        end
                        else if (format_mode == pnm_pkg::MODE_P2)
                        begin
                            push           = 1'b1;
                            push_cmd.red   = number_accumulator_reg;
                            push_cmd.green = number_accumulator_reg;
                            push_cmd.blue  = number_accumulator_reg;
                        end
                        else
                        begin
                            rgb_take  = 1'b1;
                            rgb_value = number_accumulator_reg;
                        end
                    end
                end
                pnm_pkg::MODE_P4:
                begin
                    if (!raster.end_of_data)
                    begin
                        push          = 1'b1;
                        push_cmd.kind = pnm_pkg::CMD_MONO8;
                    end
                end
                pnm_pkg::MODE_P5:
                begin
                    push = !raster.end_of_data;
                end
                pnm_pkg::MODE_P6:
                begin
                    rgb_take = !raster.end_of_data;
                end
                default:
                begin
                    // unknown mode: drop the byte
                end
            endcase
        end

        if (rgb_take)
        begin
            case (component_index_reg)
                2'd1:
                begin
                    held_green_next      = rgb_value;
                    component_index_next = 2'd2;
                end
                2'd2:
                begin
                    component_index_next = 2'd0;
                    push                 = 1'b1;
                    push_cmd.red         = held_red_reg;
                    push_cmd.green       = held_green_reg;
                    push_cmd.blue        = rgb_value;
                end
                default:
                begin
                    held_red_next        = rgb_value;
                    component_index_next = 2'd1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            component_index_reg    <= 2'd0;
            held_red_reg           <= 8'd0;
            held_green_reg         <= 8'd0;
            number_accumulator_reg <= 8'd0;
            digits_pending_reg     <= 1'b0;
        end
        else
        begin
            component_index_reg    <= component_index_next;
            held_red_reg           <= held_red_next;
            held_green_reg         <= held_green_next;
            number_accumulator_reg <= number_accumulator_next;
            digits_pending_reg     <= digits_pending_next;
        end
    end

    // A nonzero accumulator is only seen while digits are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !digits_pending_reg |-> number_accumulator_reg == 8'd0)
        else $error("accumulator not cleared without pending digits");

    // Only a P4 byte yields a multi-pixel command
    assert property (@(posedge clk) disable iff (!rst_n)
        push && push_cmd.kind == pnm_pkg::CMD_MONO8 |-> format_mode == pnm_pkg::MODE_P4)
        else $error("bitmap command outside P4");

    // Nothing enters the queue without an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> accept)
        else $error("queue push without accepted beat");

endmodule

// ===== sv/pnm_fifo.sv =====
// Short command queue between the front end and the pixel engine.
module pnm_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pnm_pkg::pnm_cmd_t  push_cmd,
    input  logic               pop,
    output pnm_pkg::pnm_cmd_t  head_cmd,
    output logic               head_valid,
    output logic               full
);

    pnm_pkg::pnm_cmd_t                entry_reg [pnm_pkg::FIFO_DEPTH];
    logic [pnm_pkg::FIFO_AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [pnm_pkg::FIFO_CW-1:0]      count_reg;

    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign head_valid = count_reg != '0;
    assign full       = count_reg == pnm_pkg::FIFO_CW'(pnm_pkg::FIFO_DEPTH);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("pop from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pnm_pkg::FIFO_CW'(pnm_pkg::FIFO_DEPTH))
        else $error("queue count overflow");

endmodule

// ===== sv/pnm_back.sv =====
// Pixel engine: expands commands into pixels, tracks columns, drives output.
module pnm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        row_width,
    input  pnm_pkg::pnm_cmd_t  head_cmd,
    input  logic               head_valid,
    output logic               pop,
    pnm_out_if.source          pixel
);

    logic [15:0] column_count_reg, column_count_next;
    logic [2:0]  bit_pos_reg, bit_pos_next;
    logic        out_valid_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic        row_end_reg, run_last_reg;

    logic        emit;
    logic [16:0] col_plus_one;
    logic [16:0] width_ext;
    logic        row_done;
    logic        cmd_done;
    logic [7:0]  mono_value;

    assign emit         = head_valid && (!out_valid_reg || pixel.ready);
    assign col_plus_one = {1'b0, column_count_reg} + 17'd1;
    assign width_ext    = (row_width == 16'd0) ? 17'h10000 : {1'b0, row_width};
    assign row_done     = col_plus_one >= width_ext;
    assign mono_value   = pnm_pkg::mono_level(head_cmd.red[~bit_pos_reg]);
    assign cmd_done     = (head_cmd.kind == pnm_pkg::CMD_PIXEL) || row_done
                        || (bit_pos_reg == 3'd7);
    assign pop          = emit && cmd_done;

    always_comb
    begin
        column_count_next = column_count_reg;
        bit_pos_next      = bit_pos_reg;
        if (emit)
        begin
            column_count_next = row_done ? 16'd0 : col_plus_one[15:0];
            bit_pos_next      = cmd_done ? 3'd0 : bit_pos_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= 16'd0;
            bit_pos_reg      <= 3'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            bit_pos_reg      <= bit_pos_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixel.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (head_cmd.kind == pnm_pkg::CMD_MONO8)
            begin
                red_reg   <= mono_value;
                green_reg <= mono_value;
                blue_reg  <= mono_value;
            end
            else
            begin
                red_reg   <= head_cmd.red;
                green_reg <= head_cmd.green;
                blue_reg  <= head_cmd.blue;
            end
            row_end_reg  <= row_done;
            run_last_reg <= cmd_done;
        end
    end

    assign pixel.valid    = out_valid_reg;
    assign pixel.red      = red_reg;
    assign pixel.green    = green_reg;
    assign pixel.blue     = blue_reg;
    assign pixel.alpha    = pnm_pkg::ALPHA_OPAQUE;
    assign pixel.row_end  = row_end_reg;
    assign pixel.run_last = run_last_reg;

    // Mid-byte position only while a bitmap byte sits at the queue head
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_pos_reg != 3'd0 |-> head_valid && head_cmd.kind == pnm_pkg::CMD_MONO8)
        else $error("bit position set without bitmap command");

    // A row end restarts the column count
    assert property (@(posedge clk) disable iff (!rst_n)
        emit && row_done |=> column_count_reg == 16'd0)
        else $error("column count not cleared at row end");

    // A row end always finishes the current command
    assert property (@(posedge clk) disable iff (!rst_n)
        emit && row_done |-> pop)
        else $error("row end did not retire command");

endmodule

// ===== tb/tb_pnm_raster_to_rgba_expander.sv =====
// Self-checking testbench for the PNM raster to RGBA pixel expander.
`timescale 1ns / 100ps

module tb_pnm_raster_to_rgba_expander;

    // Mode digits outside the PNM range; the block swallows bytes in these modes
    localparam logic [2:0] MODE_UNUSED_LO = 3'd0;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    // ASCII characters used by the number parser
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam int SETTLE_CYCLES  = 16;    // front end idle time after the last pixel
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any beat before giving up
    localparam int RANDOM_ITEMS   = 290;
    localparam int HOLDOFF_CYCLES = 400;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       row_end;
        logic       run_last;
    } rgba_px_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    pnm_in_if  raster_ch ();
    pnm_out_if pixel_ch ();

    pnm_raster_to_rgba_expander dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .raster    (raster_ch),
        .pixel     (pixel_ch)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Pixel predictor: a private copy of the registers and the parser state
    // ------------------------------------------------------------------
    logic [2:0]  mode_q   = pnm_pkg::FORMAT_MODE_RESET;
    logic [15:0] width_q  = pnm_pkg::ROW_WIDTH_RESET;
    logic [15:0] col_q    = '0;
    logic [1:0]  comp_q   = '0;
    logic [7:0]  hold_r_q = '0;
    logic [7:0]  hold_g_q = '0;
    logic [7:0]  acc_q    = '0;
    logic        pend_q   = 1'b0;

    rgba_px_t run_buf [8];   // pixels caused by the beat being predicted
    int       run_len;
    rgba_px_t pixel_expect_q [$];

    int  err_count   = 0;
    int  idle_cycles = 0;
    bit  src_idle_on = 1'b0;
    bit  sink_idle_on = 1'b0;
    int  sink_hold_left = 0;
    int  sink_gap_left  = 0;

    // Append one pixel to the current run and advance the column.
    // A width of zero stands for a row of 65536 pixels.
    function automatic void put_pixel(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
        logic [16:0] span;
        logic [16:0] nxt;
        logic        last_col;
        span     = (width_q == 16'd0) ? 17'h10000 : {1'b0, width_q};
        nxt      = {1'b0, col_q} + 17'd1;
        last_col = (nxt >= span);   // also ends the row when the width was lowered
        if (run_len >= 8)
            return;
        run_buf[run_len] = '{r, g, b, pnm_pkg::ALPHA_OPAQUE, last_col, 1'b0};
        col_q   = last_col ? 16'd0 : nxt[15:0];
        run_len = run_len + 1;
    endfunction

    // Collect R, G, B in turn; the index and held values are shared by P6 and P3.
    function automatic void take_component(input logic [7:0] v);
        logic [1:0] idx;
        idx = (comp_q == 2'd3) ? 2'd0 : comp_q;
        if (idx == 2'd0)
        begin
            hold_r_q = v;
            comp_q   = 2'd1;
        end
        else if (idx == 2'd1)
        begin
            hold_g_q = v;
            comp_q   = 2'd2;
        end
        else
        begin
            comp_q = 2'd0;
            put_pixel(hold_r_q, hold_g_q, v);
        end
    endfunction

    // Close a pending ASCII number; only its low eight bits survive.
    function automatic void close_number();
        logic [7:0] v;
        logic [7:0] lvl;
        v = acc_q;
        if (!pend_q)
            return;
        pend_q = 1'b0;
        acc_q  = '0;
        if (mode_q == pnm_pkg::MODE_P1)
        begin
            lvl = (v != 8'd0) ? pnm_pkg::LEVEL_BLACK : pnm_pkg::LEVEL_WHITE;
            put_pixel(lvl, lvl, lvl);
        end
        else if (mode_q == pnm_pkg::MODE_P2)
            put_pixel(v, v, v);
        else
            take_component(v);
    endfunction

    // Work out the pixels of one accepted raster beat and queue them.
    function automatic void expand_beat(input logic [7:0] b, input logic e);
        logic [7:0] lvl;
        run_len = 0;
        case (mode_q)
            pnm_pkg::MODE_P1, pnm_pkg::MODE_P2, pnm_pkg::MODE_P3:
            begin
                if (e)
                    close_number();
                else if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    acc_q  = acc_q * 8'd10 + (b - CH_ZERO);
                    pend_q = 1'b1;
                end
                else
                    close_number();
            end
            pnm_pkg::MODE_P4:
            begin
                if (!e)
                begin
                    // MSB first; drop the rest of the byte once the row is full
                    for (int k = 7; k >= 0; k--)
                    begin
                        lvl = b[k] ? pnm_pkg::LEVEL_BLACK : pnm_pkg::LEVEL_WHITE;
                        put_pixel(lvl, lvl, lvl);
                        if (run_buf[run_len - 1].row_end)
                            break;
                    end
                end
            end
            pnm_pkg::MODE_P5:
            begin
                if (!e)
                    put_pixel(b, b, b);
            end
            pnm_pkg::MODE_P6:
            begin
                if (!e)
                    take_component(b);
            end
            default:
            begin
            end
        endcase
        if (run_len > 0)
            run_buf[run_len - 1].run_last = 1'b1;
        for (int i = 0; i < run_len; i++)
            pixel_expect_q.push_back(run_buf[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Gap length: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offer one raster beat and hold it until the block takes it.
    task automatic send_beat(input logic [7:0] b, input logic e);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            raster_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        raster_ch.valid       = 1'b1;
        raster_ch.data_byte   = b;
        raster_ch.end_of_data = e;
        do
            @(posedge clk);
        while (!raster_ch.ready);
        expand_beat(b, e);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    // End of data carries a random byte, which the block must ignore.
    task automatic send_eod();
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        send_beat(junk, 1'b1);
    endtask

    task automatic send_random_bytes(input int count);
        logic [7:0] b;
        for (int i = 0; i < count; i++)
        begin
            b = 8'($urandom_range(0, 255));
            send_beat(b, ($urandom_range(0, 24) == 0));
        end
    endtask

    // Drop valid and wait until every predicted pixel has come out.
    task automatic wait_drained();
        @(negedge clk);
        raster_ch.valid = 1'b0;
        while (pixel_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // Write one register with the block idle; a digit still in the front end
    // yields no pixel, so give it time to settle first.
    task automatic write_reg(input logic idx, input logic [15:0] val);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == pnm_pkg::REG_FORMAT_MODE)
            mode_q = val[2:0];
        else
            width_q = val;
    endtask

    // Only the low three bits select the mode; fill the rest with noise.
    task automatic set_mode(input logic [2:0] m);
        logic [12:0] junk;
        junk = 13'($urandom_range(0, 8191));
        write_reg(pnm_pkg::REG_FORMAT_MODE, {junk, m});
    endtask

    // ------------------------------------------------------------------
    // Pixel sink: random stalls, plus a long hold-off counted down here
    // ------------------------------------------------------------------
    initial
    begin
        pixel_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_left > 0)
            begin
                pixel_ch.ready = 1'b0;
                sink_hold_left = sink_hold_left - 1;
            end
            else if (sink_gap_left > 0)
            begin
                pixel_ch.ready = 1'b0;
                sink_gap_left  = sink_gap_left - 1;
            end
            else
            begin
                pixel_ch.ready = 1'b1;
                if (sink_idle_on && $urandom_range(0, 3) == 0)
                    sink_gap_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel checker: compare each beat with the oldest prediction
    // ------------------------------------------------------------------
    rgba_px_t got_px;
    rgba_px_t exp_px;

    task automatic report_mismatch(input string what, input rgba_px_t want,
                                   input rgba_px_t seen);
        err_count = err_count + 1;
        if (err_count <= 10)
            $display({"%0t %s: expected rgba=%0d,%0d,%0d,%0d row_end=%0b run_last=%0b,",
                      " got rgba=%0d,%0d,%0d,%0d row_end=%0b run_last=%0b"},
                     $realtime, what,
                     want.red, want.green, want.blue, want.alpha, want.row_end,
                     want.run_last,
                     seen.red, seen.green, seen.blue, seen.alpha, seen.row_end,
                     seen.run_last);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pixel_ch.valid && pixel_ch.ready)
        begin
            got_px = '{pixel_ch.red, pixel_ch.green, pixel_ch.blue, pixel_ch.alpha,
                       pixel_ch.row_end, pixel_ch.run_last};
            if (pixel_expect_q.size() == 0)
                report_mismatch("unexpected pixel", '0, got_px);
            else
            begin
                exp_px = pixel_expect_q.pop_front();
                if (got_px !== exp_px)
                    report_mismatch("pixel mismatch", exp_px, got_px);
            end
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((raster_ch.valid && raster_ch.ready) || (pixel_ch.valid && pixel_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[pnm_raster_to_rgba_expander] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // P6: first under the reset settings (P6, one pixel per row), then a
    // two-pixel row with extreme components; end of data is a no-op here.
    task automatic test_rgb_binary();
        send_beat(8'h00, 1'b0);
        send_beat(8'hff, 1'b0);
        send_beat(8'h80, 1'b0);
        write_reg(pnm_pkg::REG_ROW_WIDTH, 16'd2);
        send_text("\xff\x01\x7f");
        send_eod();
        send_beat(8'h55, 1'b0);
        send_beat(8'haa, 1'b0);
        send_beat(8'h00, 1'b0);
    endtask

    // P5: one grey byte per pixel, copied to all three components.
    task automatic test_grey_binary();
        set_mode(pnm_pkg::MODE_P5);
        write_reg(pnm_pkg::REG_ROW_WIDTH, 16'd3);
        send_beat(8'h00, 1'b0);
        send_beat(8'hff, 1'b0);
        send_eod();
    endtask

    // P4: eight pixels per byte, with the tail of a byte dropped at a row end.
    task automatic test_bitmap_binary();
        set_mode(pnm_pkg::MODE_P4);
        write_reg(pnm_pkg::REG_ROW_WIDTH, 16'd3);
        send_text("\xa5");
        write_reg(pnm_pkg::REG_ROW_WIDTH, 16'd11);
        send_text("\x5a\xc3");
        send_eod();
    endtask

    // ASCII modes: overflow to the low eight bits, mixed separators, end of
    // data closing a number, P1 treating any nonzero value as black.
    task automatic test_ascii_numbers();
        set_mode(pnm_pkg::MODE_P2);
        write_reg(pnm_pkg::REG_ROW_WIDTH, 16'd2);
        send_text("300 255\t0,,9");
        send_eod();
        send_eod();
        set_mode(pnm_pkg::MODE_P1);
        send_text("5;256 0\n1000");
        send_eod();
        set_mode(pnm_pkg::MODE_P3);
        send_text("1 2 3 255 0\x80128 ");
    endtask

    // Corner settings: width lowered mid-row, width zero and maximum, a mode
    // switch in the middle of an RGB pixel, and the unused mode digits.
    task automatic test_odd_settings();
        set_mode(pnm_pkg::MODE_P5);
        write_reg(pnm_pkg::REG_ROW_WIDTH, 16'd5);
        send_text("\x01\x02\x03");
        write_reg(pnm_pkg::REG_ROW_WIDTH, 16'd2);
        send_text("\x04\x05");
        write_reg(pnm_pkg::REG_ROW_WIDTH, 16'd0);
        send_text("\x06\x07");
        write_reg(pnm_pkg::REG_ROW_WIDTH, 16'hffff);
        send_text("\x08");
        set_mode(pnm_pkg::MODE_P6);
        send_text("\x11");
        set_mode(pnm_pkg::MODE_P3);
        send_text("7 8 9 ");
        set_mode(pnm_pkg::MODE_P6);
        send_text("\x22\x33");
        set_mode(MODE_UNUSED_HI);
        send_text("\x31 ");
        set_mode(MODE_UNUSED_LO);
        send_eod();
    endtask

    // Hold the sink off for a long stretch while the sender keeps offering
    // full P4 bytes, so the command queue fills and stalls the raster side.
    task automatic test_backpressure();
        set_mode(pnm_pkg::MODE_P4);
        write_reg(pnm_pkg::REG_ROW_WIDTH, 16'd8);
        src_idle_on    = 1'b0;
        sink_idle_on   = 1'b0;
        sink_hold_left = HOLDOFF_CYCLES;
        send_random_bytes(24);
    endtask

    // Let the block drain completely in the middle of a stream, then resume.
    task automatic test_pause_for_drain();
        set_mode(pnm_pkg::MODE_P6);
        write_reg(pnm_pkg::REG_ROW_WIDTH, 16'd5);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_random_bytes(10);
        wait_drained();
        repeat ($urandom_range(1, 20)) @(negedge clk);
        send_random_bytes(11);
    endtask

    // Mostly well-formed numbers with separators; some noise and stray ends.
    task automatic send_ascii_burst(input int count);
        int         sent;
        int         r;
        int         ndig;
        logic [7:0] b;
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6)
                                                   : $urandom_range(1, 3);
                for (int i = 0; i < ndig; i++)
                begin
                    b = (i == 0 && $urandom_range(0, 3) == 0)
                        ? CH_ZERO : 8'(CH_ZERO + $urandom_range(0, 9));
                    send_beat(b, 1'b0);
                end
                sent = sent + ndig;
                repeat ($urandom_range(1, 2))
                begin
                    case ($urandom_range(0, 3))
                        0: b = CH_SPACE;
                        1: b = CH_LF;
                        2: b = CH_TAB;
                        default:
                        begin
                            b = 8'($urandom_range(0, 255));
                            if (b >= CH_ZERO && b <= CH_NINE)
                                b = CH_SPACE;
                        end
                    endcase
                    send_beat(b, 1'b0);
                    sent = sent + 1;
                end
            end
            else if (r < 95)
            begin
                b = 8'($urandom_range(0, 255));
                send_beat(b, 1'b0);
                sent = sent + 1;
            end
            else
            begin
                send_eod();
                sent = sent + 1;
            end
        end
    endtask

    // Random phases, each with its own mode, width and idling pattern.
    // The width is left alone in some phases so rows carry across settings.
    task automatic test_random_mix();
        int          sent;
        int          burst;
        int          r;
        logic [2:0]  m;
        logic [15:0] w;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 19);
            m = (r == 0) ? (($urandom_range(0, 1) == 0) ? MODE_UNUSED_LO : MODE_UNUSED_HI)
                         : 3'($urandom_range(1, 6));
            set_mode(m);
            if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 9))
                    0: w = 16'd1;
                    1: w = 16'hffff;
                    2: w = 16'd0;
                    default: w = 16'($urandom_range(2, 12));
                endcase
                write_reg(pnm_pkg::REG_ROW_WIDTH, w);
            end
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            burst = $urandom_range(15, 40);
            if (r == 0)
                send_random_bytes(6);   // swallowed, so not counted
            else
            begin
                if (m == pnm_pkg::MODE_P1 || m == pnm_pkg::MODE_P2
                    || m == pnm_pkg::MODE_P3)
                    send_ascii_burst(burst);
                else
                    send_random_bytes(burst);
                sent = sent + burst;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = pnm_pkg::REG_FORMAT_MODE;
        cfg_wdata             = '0;
        raster_ch.valid       = 1'b0;
        raster_ch.data_byte   = '0;
        raster_ch.end_of_data = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_rgb_binary();
        test_grey_binary();
        test_bitmap_binary();
        test_ascii_numbers();
        test_odd_settings();
        test_backpressure();
        test_pause_for_drain();
        test_random_mix();

        // Let the tail drain, then allow a little extra time for strays.
        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0 && pixel_expect_q.size() == 0)
            $display("[pnm_raster_to_rgba_expander] OK");
        else
            $display("[pnm_raster_to_rgba_expander] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pnm_pkg.sv
sv/pnm_in_if.sv
sv/pnm_out_if.sv
sv/pnm_front.sv
sv/pnm_fifo.sv
sv/pnm_back.sv
sv/pnm_raster_to_rgba_expander.sv
tb/tb_pnm_raster_to_rgba_expander.sv
